/* rtl/dtt_pkg.sv */
`timescale 1ns / 1ps
package dtt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int MAX_OUT    = 16;
  localparam int K_W        = $clog2(MAX_OUT + 1);
  localparam int TIME_W     = 48;
  localparam int PERIOD_W   = 32;
  localparam int FUNC_W     = 3;
  localparam int HANDLE_W   = 4;
  localparam int SLOT_W     = 4;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CANCEL  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REFRESH = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RESET   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TICK    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_NEXT    = 3'd5;

  localparam logic [PERIOD_W-1:0] WAIT_NONE = '1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [PERIOD_W-1:0] period_t;

  typedef enum logic [1:0] {
    SC_ADD   = 2'd0,
    SC_FRONT = 2'd1,
    SC_TICK  = 2'd2,
    SC_MIN   = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic              expired;
    logic              front_notify;
    period_t           wait_ms;
    logic              none_pending;
    logic              last;
  } res_t;

  typedef struct packed {
    idx_t    rd_addr;
    logic    dl_we;
    logic    pd_we;
    idx_t    wr_addr;
    time_t   wr_dl;
    period_t wr_pd;
  } mem_req_t;

  typedef struct packed {
    time_t   rd_dl;
    period_t rd_pd;
  } mem_rsp_t;

endpackage

/* rtl/dtt_store.sv */
`timescale 1ns / 1ps
module dtt_store (
  input  logic              clk,
  input  dtt_pkg::mem_req_t req,
  output dtt_pkg::mem_rsp_t rsp
);
  import dtt_pkg::*;

  time_t   dl_mem [NUM_TIMERS];
  period_t pd_mem [NUM_TIMERS];

  // write deadline and period entries
  always_ff @(posedge clk) begin
    if (req.dl_we) begin
      dl_mem[req.wr_addr] <= req.wr_dl;
    end
    if (req.pd_we) begin
      pd_mem[req.wr_addr] <= req.wr_pd;
    end
  end

  // registered read of both entries at one address
  always_ff @(posedge clk) begin
    rsp.rd_dl <= dl_mem[req.rd_addr];
    rsp.rd_pd <= pd_mem[req.rd_addr];
  end

endmodule

/* rtl/dtt_ctrl.sv */
`timescale 1ns / 1ps
module dtt_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dtt_pkg::FUNC_W-1:0]      in_func,
  input  logic [dtt_pkg::HANDLE_W-1:0]    in_handle,
  input  logic [dtt_pkg::PERIOD_W-1:0]    in_period_ms,
  input  logic                            in_recurring,
  input  logic                            in_from_now,
  output logic                            res_valid,
  input  logic                            res_ready,
  output dtt_pkg::res_t                   res,
  output dtt_pkg::mem_req_t               req,
  input  dtt_pkg::mem_rsp_t               rsp
);
  import dtt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_RD    = 6'b000100,
    S_CALC  = 6'b001000,
    S_NQFIN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt, ret_r, ret_nxt;
  scan_mode_t             mode_r, mode_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [FUNC_W-1:0]      op_r, op_nxt;
  idx_t                   tgt_r, tgt_nxt;
  period_t                ms_r, ms_nxt;
  logic                   rec_r, rec_nxt;
  logic                   fnow_r, fnow_nxt;
  time_t                  dnew_r, dnew_nxt;
  time_t                  now_r, now_nxt;
  logic                   notice_r, notice_nxt;
  logic [NUM_TIMERS-1:0]  active_r, active_nxt;
  logic [NUM_TIMERS-1:0]  rep_r, rep_nxt;
  logic [NUM_TIMERS-1:0]  done_r, done_nxt;
  logic [K_W-1:0]         k_r, k_nxt;
  logic                   have_pend_r, have_pend_nxt;
  res_t                   pend_r, pend_nxt;
  res_t                   res_r, res_nxt;
  logic                   found_r, found_nxt;
  idx_t                   best_idx_r, best_idx_nxt;
  time_t                  best_dl_r, best_dl_nxt;
  logic                   blocked_r, blocked_nxt;
  logic                   free_found_r, free_found_nxt;
  idx_t                   free_idx_r, free_idx_nxt;

  // entry under evaluation: read issued in the previous cycle
  logic  ent_vld;
  idx_t  ent_idx;
  logic  ent_act;
  time_t ent_dl;
  assign ent_vld = (cnt_r != '0);
  assign ent_idx = idx_t'(cnt_r - CNT_W'(1));
  assign ent_act = active_r[ent_idx];
  assign ent_dl  = rsp.rd_dl;

  // scan accumulators after this cycle's entry
  logic  found_c, blocked_c, free_found_c;
  idx_t  best_idx_c, free_idx_c;
  time_t best_dl_c;

  always_comb begin
    found_c      = found_r;
    best_idx_c   = best_idx_r;
    best_dl_c    = best_dl_r;
    blocked_c    = blocked_r;
    free_found_c = free_found_r;
    free_idx_c   = free_idx_r;
    if (state_r == S_SCAN && ent_vld) begin
      case (mode_r)
        SC_ADD: begin
          if (!free_found_r) begin
            if (!ent_act) begin
              free_found_c = 1'b1;
              free_idx_c   = ent_idx;
            end else if (ent_dl <= dnew_r) begin
              blocked_c = 1'b1;
            end
          end else if (ent_act && ent_dl < dnew_r) begin
            blocked_c = 1'b1;
          end
        end
        SC_FRONT: begin
          if (ent_act && ent_idx != tgt_r &&
              (ent_dl < dnew_r || (ent_dl == dnew_r && ent_idx < tgt_r))) begin
            blocked_c = 1'b1;
          end
        end
        SC_TICK: begin
          if (ent_act && !done_r[ent_idx] && ent_dl <= now_r &&
              (!found_r || ent_dl < best_dl_r)) begin
            found_c    = 1'b1;
            best_idx_c = ent_idx;
            best_dl_c  = ent_dl;
          end
        end
        default: begin
          if (ent_act && (!found_r || ent_dl < best_dl_r)) begin
            found_c    = 1'b1;
            best_idx_c = ent_idx;
            best_dl_c  = ent_dl;
          end
        end
      endcase
    end
  end

  // sequencer
  state_t go;
  logic   emit;
  logic   scan_start;
  logic   fn;
  logic   h_ok;
  idx_t   h_idx;
  res_t   r;
  time_t  diff;

  assign h_ok  = (32'(in_handle) < NUM_TIMERS);
  assign h_idx = idx_t'(in_handle);
  assign fn    = !blocked_c && !notice_r;
  assign diff  = best_dl_r - now_r;

  always_comb begin
    go             = state_r;
    emit           = 1'b0;
    scan_start     = 1'b0;
    r              = '0;
    r.last         = 1'b1;
    ret_nxt        = ret_r;
    res_nxt        = res_r;
    mode_nxt       = mode_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    tgt_nxt        = tgt_r;
    ms_nxt         = ms_r;
    rec_nxt        = rec_r;
    fnow_nxt       = fnow_r;
    dnew_nxt       = dnew_r;
    now_nxt        = now_r;
    notice_nxt     = notice_r;
    active_nxt     = active_r;
    rep_nxt        = rep_r;
    done_nxt       = done_r;
    k_nxt          = k_r;
    have_pend_nxt  = have_pend_r;
    pend_nxt       = pend_r;
    found_nxt      = found_c;
    best_idx_nxt   = best_idx_c;
    best_dl_nxt    = best_dl_c;
    blocked_nxt    = blocked_c;
    free_found_nxt = free_found_c;
    free_idx_nxt   = free_idx_c;
    req            = '0;
    req.rd_addr    = idx_t'(cnt_r);
    req.wr_addr    = tgt_r;
    req.wr_dl      = dnew_r;
    req.wr_pd      = ms_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_func;
          tgt_nxt  = h_idx;
          ms_nxt   = in_period_ms;
          rec_nxt  = in_recurring;
          fnow_nxt = in_from_now;
          unique case (in_func)
            FN_ADD: begin
              dnew_nxt   = now_r + TIME_W'(in_period_ms);
              mode_nxt   = SC_ADD;
              scan_start = 1'b1;
              go         = S_SCAN;
            end
            FN_CANCEL: begin
              emit = 1'b1;
              go   = S_IDLE;
              if (h_ok && active_r[h_idx]) begin
                active_nxt[h_idx] = 1'b0;
                r.ok              = 1'b1;
              end
            end
            FN_REFRESH: begin
              if (h_ok && active_r[h_idx]) begin
                req.rd_addr = h_idx;
                go          = S_CALC;
              end else begin
                emit = 1'b1;
                go   = S_IDLE;
              end
            end
            FN_RESET: begin
              if (h_ok) begin
                req.rd_addr = h_idx;
                go          = S_CALC;
              end else begin
                emit = 1'b1;
                go   = S_IDLE;
              end
            end
            FN_TICK: begin
              now_nxt       = now_r + TIME_W'(1);
              done_nxt      = '0;
              k_nxt         = '0;
              have_pend_nxt = 1'b0;
              mode_nxt      = SC_TICK;
              scan_start    = 1'b1;
              go            = S_SCAN;
            end
            FN_NEXT: begin
              notice_nxt = 1'b0;
              mode_nxt   = SC_MIN;
              scan_start = 1'b1;
              go         = S_SCAN;
            end
            default: begin
              emit = 1'b1;
              go   = S_IDLE;
            end
          endcase
        end
      end

      S_RD: begin
        // fetch the period of the expired recurring timer
        req.rd_addr = tgt_r;
        go          = S_CALC;
      end

      S_CALC: begin
        case (op_r)
          FN_REFRESH: begin
            req.dl_we = 1'b1;
            req.wr_dl = now_r + TIME_W'(rsp.rd_pd);
            r.ok      = 1'b1;
            emit      = 1'b1;
            go        = S_IDLE;
          end
          FN_RESET: begin
            if (ms_r == rsp.rd_pd && !fnow_r) begin
              r.ok = 1'b1;
              emit = 1'b1;
              go   = S_IDLE;
            end else if (!active_r[tgt_r]) begin
              emit = 1'b1;
              go   = S_IDLE;
            end else begin
              if (fnow_r) begin
                dnew_nxt = now_r + TIME_W'(ms_r);
              end else begin
                dnew_nxt = rsp.rd_dl - TIME_W'(rsp.rd_pd) + TIME_W'(ms_r);
              end
              mode_nxt   = SC_FRONT;
              scan_start = 1'b1;
              go         = S_SCAN;
            end
          end
          FN_TICK: begin
            dnew_nxt   = now_r + TIME_W'(rsp.rd_pd);
            mode_nxt   = SC_FRONT;
            scan_start = 1'b1;
            go         = S_SCAN;
          end
          default: begin
            go = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_TIMERS)) begin
          case (mode_r)
            SC_ADD: begin
              emit = 1'b1;
              go   = S_IDLE;
              if (free_found_c) begin
                req.dl_we              = 1'b1;
                req.pd_we              = 1'b1;
                req.wr_addr            = free_idx_c;
                active_nxt[free_idx_c] = 1'b1;
                rep_nxt[free_idx_c]    = rec_r;
                notice_nxt             = notice_r | fn;
                r.ok                   = 1'b1;
                r.slot                 = SLOT_W'(free_idx_c);
                r.front_notify         = fn;
              end
            end
            SC_FRONT: begin
              req.dl_we  = 1'b1;
              req.pd_we  = (op_r == FN_RESET);
              notice_nxt = notice_r | fn;
              if (op_r == FN_RESET) begin
                r.ok           = 1'b1;
                r.front_notify = fn;
                emit           = 1'b1;
                go             = S_IDLE;
              end else begin
                // hold the expiry until the next search settles its last flag
                pend_nxt              = '0;
                pend_nxt.ok           = 1'b1;
                pend_nxt.slot         = SLOT_W'(tgt_r);
                pend_nxt.expired      = 1'b1;
                pend_nxt.front_notify = fn;
                have_pend_nxt         = 1'b1;
                k_nxt                 = k_r + K_W'(1);
                if (k_r + K_W'(1) == K_W'(MAX_OUT)) begin
                  r      = pend_nxt;
                  r.last = 1'b1;
                  emit   = 1'b1;
                  go     = S_IDLE;
                end else begin
                  mode_nxt   = SC_TICK;
                  scan_start = 1'b1;
                  go         = S_SCAN;
                end
              end
            end
            SC_TICK: begin
              if (found_c) begin
                if (have_pend_r) begin
                  r      = pend_r;
                  r.last = 1'b0;
                  emit   = 1'b1;
                end
                done_nxt[best_idx_c] = 1'b1;
                tgt_nxt              = best_idx_c;
                if (rep_r[best_idx_c]) begin
                  have_pend_nxt = 1'b0;
                  go            = S_RD;
                end else begin
                  active_nxt[best_idx_c] = 1'b0;
                  pend_nxt               = '0;
                  pend_nxt.ok            = 1'b1;
                  pend_nxt.slot          = SLOT_W'(best_idx_c);
                  pend_nxt.expired       = 1'b1;
                  have_pend_nxt          = 1'b1;
                  k_nxt                  = k_r + K_W'(1);
                  if (k_r + K_W'(1) == K_W'(MAX_OUT)) begin
                    // expiry limit reached: the fresh expiry is the final one
                    pend_nxt.last = 1'b1;
                    if (have_pend_r) begin
                      // emit the held result, then the final one from pend_r
                      go = S_EMIT;
                    end else begin
                      r    = pend_nxt;
                      emit = 1'b1;
                      go   = S_IDLE;
                    end
                  end else begin
                    mode_nxt   = SC_TICK;
                    scan_start = 1'b1;
                    go         = S_SCAN;
                  end
                end
              end else begin
                if (have_pend_r) begin
                  r = pend_r;
                end else begin
                  r.ok = 1'b1;
                end
                r.last = 1'b1;
                emit   = 1'b1;
                go     = S_IDLE;
              end
            end
            default: begin
              go = S_NQFIN;
            end
          endcase
        end
      end

      S_NQFIN: begin
        r.ok = 1'b1;
        if (!found_r) begin
          r.none_pending = 1'b1;
          r.wait_ms      = WAIT_NONE;
        end else if (now_r >= best_dl_r) begin
          r.wait_ms = '0;
        end else if (|diff[TIME_W-1:PERIOD_W]) begin
          r.wait_ms = WAIT_NONE;
        end else begin
          r.wait_ms = diff[PERIOD_W-1:0];
        end
        emit = 1'b1;
        go   = S_IDLE;
      end

      S_EMIT: begin
        if (res_ready) begin
          go = ret_r;
          // final expiry of a full tick waits in the held result
          if (ret_r == S_EMIT) begin
            res_nxt = pend_r;
            ret_nxt = S_IDLE;
          end
        end
      end

      default: begin
        go = S_IDLE;
      end
    endcase

    // clear the scan accumulators for a new pass
    if (scan_start) begin
      cnt_nxt        = '0;
      found_nxt      = 1'b0;
      blocked_nxt    = 1'b0;
      free_found_nxt = 1'b0;
    end

    if (emit) begin
      res_nxt   = r;
      ret_nxt   = go;
      state_nxt = S_EMIT;
    end else begin
      state_nxt = go;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_EMIT);
  assign res       = res_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      now_r       <= '0;
      notice_r    <= 1'b0;
      active_r    <= '0;
      rep_r       <= '0;
      done_r      <= '0;
      k_r         <= '0;
      have_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      now_r       <= now_nxt;
      notice_r    <= notice_nxt;
      active_r    <= active_nxt;
      rep_r       <= rep_nxt;
      done_r      <= done_nxt;
      k_r         <= k_nxt;
      have_pend_r <= have_pend_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    res_r        <= res_nxt;
    pend_r       <= pend_nxt;
    mode_r       <= mode_nxt;
    cnt_r        <= cnt_nxt;
    op_r         <= op_nxt;
    tgt_r        <= tgt_nxt;
    ms_r         <= ms_nxt;
    rec_r        <= rec_nxt;
    fnow_r       <= fnow_nxt;
    dnew_r       <= dnew_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_dl_r    <= best_dl_nxt;
    blocked_r    <= blocked_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
  end

endmodule

/* rtl/deadline_timer_table.sv */
`timescale 1ns / 1ps
// Deadline timer table: up to NUM_TIMERS millisecond timers.
// Input channel (in_valid/in_ready) carries one operation per transaction:
// add, cancel, refresh, reset, tick or next query, selected by in_func.
// Result channel (out_valid/out_ready) returns one result per operation,
// except tick, which returns one result per expired timer (up to 16),
// earliest deadline first; out_last marks the final result of an operation.
// Add, reset, next query and tick are paced by the deadline memory's single
// read port, which the sequencer sweeps one entry per cycle for each
// free-slot, earliest-deadline or front check.
// One operation is worked at a time; in_ready is high only when idle.
// A result sits in the output register while the next operation is taken;
// when the receiver stalls, the sequencer holds at its next result.
// Reset (rst_n low, synchronous) deactivates all timers, zeroes the time
// and re-arms the front notice; period and deadline storage is not cleared.
module deadline_timer_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dtt_pkg::FUNC_W-1:0]      in_func,
  input  logic [dtt_pkg::HANDLE_W-1:0]    in_handle,
  input  logic [dtt_pkg::PERIOD_W-1:0]    in_period_ms,
  input  logic                            in_recurring,
  input  logic                            in_from_now,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_ok,
  output logic [dtt_pkg::SLOT_W-1:0]      out_slot,
  output logic                            out_expired,
  output logic                            out_front_notify,
  output logic [dtt_pkg::PERIOD_W-1:0]    out_wait_ms,
  output logic                            out_none_pending,
  output logic                            out_last
);
  import dtt_pkg::*;

  logic     res_valid;
  logic     res_ready;
  res_t     res;
  mem_req_t req;
  mem_rsp_t rsp;
  logic     out_valid_r;
  res_t     out_r;

  dtt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_handle    (in_handle),
    .in_period_ms (in_period_ms),
    .in_recurring (in_recurring),
    .in_from_now  (in_from_now),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .req          (req),
    .rsp          (rsp)
  );

  dtt_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // output register: load when empty or draining
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_r.ok;
  assign out_slot         = out_r.slot;
  assign out_expired      = out_r.expired;
  assign out_front_notify = out_r.front_notify;
  assign out_wait_ms      = out_r.wait_ms;
  assign out_none_pending = out_r.none_pending;
  assign out_last         = out_r.last;

endmodule

/* rtl/dtt_checker.sv */
`timescale 1ns / 1ps
module dtt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [dtt_pkg::FUNC_W-1:0]   in_func,
  input logic [dtt_pkg::HANDLE_W-1:0] in_handle,
  input logic [dtt_pkg::PERIOD_W-1:0] in_period_ms,
  input logic                         in_recurring,
  input logic                         in_from_now,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_ok,
  input logic [dtt_pkg::SLOT_W-1:0]   out_slot,
  input logic                         out_expired,
  input logic                         out_front_notify,
  input logic [dtt_pkg::PERIOD_W-1:0] out_wait_ms,
  input logic                         out_none_pending,
  input logic                         out_last
);
  import dtt_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_last))
    else $error("result changed while stalled");

  // one operation at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // empty table answer
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_pending |-> out_ok && out_last && out_wait_ms == WAIT_NONE)
    else $error("bad empty-table answer");

  // expiry results carry no wait
  a_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expired |-> out_ok && !out_none_pending && out_wait_ms == '0)
    else $error("bad expiry result");

  // failures carry no expiry flag, front notice or slot
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> !out_expired && !out_front_notify && out_slot == '0)
    else $error("failed transaction carries data");

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (.*);

/* test/deadline_timer_table_checker.sv */
`timescale 1ns / 1ps
module deadline_timer_table_checker
  import dtt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [PERIOD_W-1:0] in_period_ms,
  input  logic                in_recurring,
  input  logic                in_from_now,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_ok,
  input  logic [SLOT_W-1:0]   out_slot,
  input  logic                out_expired,
  input  logic                out_front_notify,
  input  logic [PERIOD_W-1:0] out_wait_ms,
  input  logic                out_none_pending,
  input  logic                out_last,
  output int                  pending,
  output int                  errors
);

  // shadow copy of the timer table
  logic    tmr_active [NUM_TIMERS];
  logic    tmr_repeat [NUM_TIMERS];
  period_t tmr_period [NUM_TIMERS];
  time_t   tmr_dl     [NUM_TIMERS];
  time_t   cur_time;
  logic    notice_out;

  res_t expected_results[$];

  assign pending = expected_results.size();

  function automatic res_t make_res(logic ok, logic [SLOT_W-1:0] slot, logic expd,
                                    logic fn, period_t wt, logic none, logic lst);
    res_t r;
    r.ok = ok; r.slot = slot; r.expired = expd; r.front_notify = fn;
    r.wait_ms = wt; r.none_pending = none; r.last = lst;
    return r;
  endfunction

  // append one expected result transaction
  function automatic void queue_result(res_t r);
    expected_results = {expected_results, r};
  endfunction

  // earliest active timer under (deadline, slot) ordering
  function automatic logic is_earliest(int s);
    for (int j = 0; j < NUM_TIMERS; j++) begin
      if (j != s && tmr_active[j] &&
          (tmr_dl[j] < tmr_dl[s] || (tmr_dl[j] == tmr_dl[s] && j < s)))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic raise_notice(int s);
    if (is_earliest(s) && !notice_out) begin
      notice_out = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one operation to the shadow table and queue its results
  task automatic predict_timer_op(logic [FUNC_W-1:0] fnc, logic [HANDLE_W-1:0] h,
                                  period_t ms, logic rec, logic fnow);
    int   s;
    int   best;
    int   k;
    logic fn;
    logic done [NUM_TIMERS];
    time_t dif;
    case (fnc)
      FN_ADD: begin
        s = 0;
        while (s < NUM_TIMERS && tmr_active[s]) s++;
        if (s >= NUM_TIMERS) begin
          queue_result(make_res(0, 0, 0, 0, 0, 0, 1));
        end else begin
          tmr_active[s] = 1'b1;
          tmr_repeat[s] = rec;
          tmr_period[s] = ms;
          tmr_dl[s]     = cur_time + time_t'(ms);
          fn = raise_notice(s);
          queue_result(make_res(1, s[SLOT_W-1:0], 0, fn, 0, 0, 1));
        end
      end
      FN_CANCEL, FN_REFRESH: begin
        if (!tmr_active[h]) begin
          queue_result(make_res(0, 0, 0, 0, 0, 0, 1));
        end else begin
          if (fnc == FN_CANCEL) tmr_active[h] = 1'b0;
          else tmr_dl[h] = cur_time + time_t'(tmr_period[h]);
          queue_result(make_res(1, 0, 0, 0, 0, 0, 1));
        end
      end
      FN_RESET: begin
        if (ms == tmr_period[h] && !fnow) begin
          queue_result(make_res(1, 0, 0, 0, 0, 0, 1));
        end else if (!tmr_active[h]) begin
          queue_result(make_res(0, 0, 0, 0, 0, 0, 1));
        end else begin
          if (fnow) tmr_dl[h] = cur_time + time_t'(ms);
          else tmr_dl[h] = tmr_dl[h] - time_t'(tmr_period[h]) + time_t'(ms);
          tmr_period[h] = ms;
          fn = raise_notice(h);
          queue_result(make_res(1, 0, 0, fn, 0, 0, 1));
        end
      end
      FN_TICK: begin
        for (int j = 0; j < NUM_TIMERS; j++) done[j] = 1'b0;
        cur_time = cur_time + time_t'(1);
        k = 0;
        best = 0;
        while (k < MAX_OUT && best >= 0) begin
          best = -1;
          for (int j = 0; j < NUM_TIMERS; j++) begin
            if (tmr_active[j] && !done[j] && tmr_dl[j] <= cur_time &&
                (best < 0 || tmr_dl[j] < tmr_dl[best]))
              best = j;
          end
          if (best >= 0) begin
            done[best] = 1'b1;
            fn = 1'b0;
            if (tmr_repeat[best]) begin
              tmr_dl[best] = cur_time + time_t'(tmr_period[best]);
              fn = raise_notice(best);
            end else begin
              tmr_active[best] = 1'b0;
            end
            queue_result(make_res(1, best[SLOT_W-1:0], 1, fn, 0, 0, 0));
            k++;
          end
        end
        if (k == 0) queue_result(make_res(1, 0, 0, 0, 0, 0, 1));
        else expected_results[$].last = 1'b1;
      end
      FN_NEXT: begin
        notice_out = 1'b0;
        best = -1;
        for (int j = 0; j < NUM_TIMERS; j++) begin
          if (tmr_active[j] && (best < 0 || tmr_dl[j] < tmr_dl[best])) best = j;
        end
        if (best < 0) begin
          queue_result(make_res(1, 0, 0, 0, WAIT_NONE, 1, 1));
        end else begin
          if (cur_time >= tmr_dl[best]) dif = '0;
          else dif = tmr_dl[best] - cur_time;
          if (dif > time_t'(WAIT_NONE)) dif = time_t'(WAIT_NONE);
          queue_result(make_res(1, 0, 0, 0, dif[PERIOD_W-1:0], 0, 1));
        end
      end
      default: queue_result(make_res(0, 0, 0, 0, 0, 0, 1));
    endcase
  endtask

  task automatic report(string name, logic [63:0] exp_v, logic [63:0] act_v);
    $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      for (int j = 0; j < NUM_TIMERS; j++) begin
        tmr_active[j] = 1'b0;
        tmr_repeat[j] = 1'b0;
        tmr_period[j] = '0;
        tmr_dl[j]     = '0;
      end
      cur_time   = '0;
      notice_out = 1'b0;
      expected_results.delete();
    end else begin
      // compare the result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, slot %0d ok %0b", $time, out_slot, out_ok);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.ok != out_ok) report("ok", want.ok, out_ok);
          if (want.slot != out_slot) report("slot", want.slot, out_slot);
          if (want.expired != out_expired) report("expired", want.expired, out_expired);
          if (want.front_notify != out_front_notify)
            report("front_notify", want.front_notify, out_front_notify);
          if (want.wait_ms != out_wait_ms) report("wait_ms", want.wait_ms, out_wait_ms);
          if (want.none_pending != out_none_pending)
            report("none_pending", want.none_pending, out_none_pending);
          if (want.last != out_last) report("last", want.last, out_last);
        end
      end
      // predict on each accepted operation
      if (in_valid && in_ready)
        predict_timer_op(in_func, in_handle, in_period_ms, in_recurring, in_from_now);
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import dtt_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func = FN_NEXT;
  logic [HANDLE_W-1:0] in_handle = '0;
  logic [PERIOD_W-1:0] in_period_ms = '0;
  logic                in_recurring = 1'b0;
  logic                in_from_now = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_ok;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_expired;
  logic                out_front_notify;
  logic [PERIOD_W-1:0] out_wait_ms;
  logic                out_none_pending;
  logic                out_last;
  int                  pending;
  int                  errors;
  logic                calm = 1'b0;

  always #10 clk = ~clk;

  deadline_timer_table i_dut (.*);

  deadline_timer_table_checker i_checker (.*);

  // drive one operation; sometimes idle first, never in a calm stretch
  task automatic send_op(logic [FUNC_W-1:0] fnc, logic [HANDLE_W-1:0] h,
                         period_t ms, logic rec, logic fnow);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= fnc;
    in_handle    <= h;
    in_period_ms <= ms;
    in_recurring <= rec;
    in_from_now  <= fnow;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic period_t pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return period_t'($urandom_range(0, 6));
    if (r < 85) return WAIT_NONE;
    return period_t'($urandom());
  endfunction

  // receiver: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 2000) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        cyc += 600;
      end else if (cyc > 4000 && cyc < 5500) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    send_op(FN_NEXT, 0, 0, 0, 0);
    send_op(FN_TICK, 0, 0, 0, 0);
    send_op(FN_CANCEL, 4'hF, 0, 0, 0);
    send_op(3'd7, 4'hA, 32'h5, 1, 1);
    // fill the table, then one add too many
    send_op(FN_ADD, 0, 0, 1, 0);
    send_op(FN_ADD, 0, WAIT_NONE, 0, 0);
    for (int i = 2; i < NUM_TIMERS; i++)
      send_op(FN_ADD, 0, period_t'(i % 3 + 1), i[0], 0);
    send_op(FN_ADD, 0, 7, 0, 0);
    // reset variants
    send_op(FN_RESET, 4'd1, WAIT_NONE, 0, 0);
    send_op(FN_RESET, 4'd2, 0, 0, 1);
    send_op(FN_RESET, 4'd3, 9, 0, 0);
    send_op(3'd6, 4'h5, WAIT_NONE, 1, 1);
    send_op(FN_TICK, 0, 0, 0, 0);

    // random operations
    for (int i = 0; i < 210; i++) begin
      calm = (i >= 120 && i < 160);
      if (i == 100) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 20)
        send_op(FN_ADD, 4'($urandom()), pick_period(), 1'($urandom()), 1'($urandom()));
      else if (r < 30)
        send_op(FN_CANCEL, 4'($urandom()), period_t'($urandom()), 1'($urandom()), 0);
      else if (r < 40)
        send_op(FN_REFRESH, 4'($urandom()), period_t'($urandom()), 0, 1'($urandom()));
      else if (r < 55)
        send_op(FN_RESET, 4'($urandom()), pick_period(), 1'($urandom()), 1'($urandom()));
      else if (r < 85)
        send_op(FN_TICK, 4'($urandom()), period_t'($urandom()), 0, 0);
      else if (r < 97)
        send_op(FN_NEXT, 4'($urandom()), period_t'($urandom()), 0, 0);
      else
        send_op(3'($urandom_range(6, 7)), 4'($urandom()), period_t'($urandom()), 0, 0);
    end
    in_valid <= 1'b0;

    // drain, then allow for a worst-case tick
    while (pending != 0) @(negedge clk);
    repeat (800) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* deadline_timer_table.f */
rtl/dtt_pkg.sv
rtl/dtt_store.sv
rtl/dtt_ctrl.sv
rtl/deadline_timer_table.sv
rtl/dtt_checker.sv
test/deadline_timer_table_checker.sv
test/testbench.sv
